// ===== rtl/srrip_pkg.sv =====
`timescale 1ns / 1ps

package srrip_pkg;

   localparam int WAYS  = 16;
   localparam int SETS  = 1024;
   localparam int SET_W = (SETS > 1) ? $clog2(SETS) : 1;
   localparam int ROW_W = 2 * WAYS;

   localparam logic [1:0] RRPV_MAX    = 2'd3;
   localparam logic [1:0] RRPV_INSERT = 2'd2;
   localparam logic [1:0] RRPV_HIT    = 2'd0;

   localparam logic [1:0] CMD_HIT   = 2'd0;
   localparam logic [1:0] CMD_FILL  = 2'd1;
   localparam logic [1:0] CMD_QUERY = 2'd2;
   localparam logic [1:0] CMD_NOP   = 2'd3;

   typedef logic [ROW_W-1:0] row_type;
   typedef logic [SET_W-1:0] addr_type;

   localparam row_type CLEAR_ROW = {WAYS{RRPV_MAX}};

   typedef struct packed {
      logic [1:0] cmd;
      logic [9:0] set_index;
      logic [3:0] way;
   } req_type;

   typedef struct packed {
      logic [3:0] victim_way;
      logic       victim_valid;
   } rsp_type;

   typedef struct packed {
      logic       wr_en;
      logic [3:0] victim_way;
      logic       victim_valid;
   } upd_ctl_type;

endpackage

// ===== rtl/srrip_replacement_policy_core.sv =====
`timescale 1ns / 1ps

// SRRIP 2-bit replacement state for a 16-way, 1024-set cache.
// Request channel (req_valid / req_stall / req_data): cmd selects a hit
// update, a miss fill, a victim query with aging or no operation for set req_data.set_index.
// Response channel (rsp_valid / rsp_stall / rsp_data): exactly one response per
// request, in request order; victim_valid marks answers to victim queries.
// Each set's prediction values sit in one row of a single-port-write,
// one-read RAM with a registered read. A request reads its row on acceptance;
// once the response register is free or draining, the row is modified and
// written back, and the response lands in the output register on that same
// edge. Throughput is one request per cycle while the receiver does not
// stall; a one-row forwarding register covers back-to-back requests to the same set.
// After reset a clearing pass writes every row to the maximum value, one row
// a cycle; req_stall stays high during it.
// When the receiver stalls, the response register holds and the request in
// flight waits; req_stall rises so no further request is taken.
module srrip_replacement_policy_core
   import srrip_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   // clearing pass
   logic     clr_ff;
   logic     clr_in;
   addr_type clr_addr_ff;
   addr_type clr_addr_in;

   // request in flight (row read issued)
   logic    s1_valid_ff;
   logic    s1_valid_in;
   req_type s1_req_ff;

   // response register
   logic    rsp_valid_ff;
   logic    rsp_valid_in;
   rsp_type rsp_data_ff;

   // last row written back
   logic     fwd_valid_ff;
   addr_type fwd_addr_ff;
   row_type  fwd_row_ff;

   logic        adv;
   logic        fire;
   logic        req_accept;
   addr_type    req_addr;
   addr_type    s1_addr;
   row_type     rd_row;
   row_type     row_cur;
   row_type     row_new;
   upd_ctl_type ctl;
   logic        mem_wr_en;
   addr_type    mem_wr_addr;
   row_type     mem_wr_data;
   logic [16:0] req_set_ext;
   logic [16:0] s1_set_ext;

   // address bits of the set index
   assign req_set_ext = 17'(req_data.set_index);
   assign s1_set_ext  = 17'(s1_req_ff.set_index);
   assign req_addr    = req_set_ext[SET_W-1:0];
   assign s1_addr     = s1_set_ext[SET_W-1:0];

   // advance the request in flight when the response slot is free or drains
   assign adv        = !rsp_valid_ff || !rsp_stall;
   assign fire       = s1_valid_ff && adv;
   assign req_stall  = clr_ff || (s1_valid_ff && !adv);
   assign req_accept = req_valid && !req_stall;

   assign s1_valid_in  = req_accept || (s1_valid_ff && !adv);
   assign rsp_valid_in = fire || (rsp_valid_ff && rsp_stall);

   // sweep rows after reset
   always_comb begin
      clr_in      = clr_ff;
      clr_addr_in = clr_addr_ff;
      if (clr_ff) begin
         if (clr_addr_ff == addr_type'(SETS - 1)) begin
            clr_in = 1'b0;
         end else begin
            clr_addr_in = clr_addr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff       <= 1'b1;
         clr_addr_ff  <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         fwd_valid_ff <= 1'b0;
      end else begin
         clr_ff       <= clr_in;
         clr_addr_ff  <= clr_addr_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (fire && ctl.wr_en) begin
            fwd_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_req_ff <= req_data;
      end
      if (fire) begin
         rsp_data_ff.victim_way   <= ctl.victim_way;
         rsp_data_ff.victim_valid <= ctl.victim_valid;
      end
      if (fire && ctl.wr_en) begin
         fwd_addr_ff <= s1_addr;
         fwd_row_ff  <= row_new;
      end
   end

   // take the last written row when it belongs to the same set
   assign row_cur = (fwd_valid_ff && (fwd_addr_ff == s1_addr)) ? fwd_row_ff : rd_row;

   always_comb begin
      if (clr_ff) begin
         mem_wr_en   = 1'b1;
         mem_wr_addr = clr_addr_ff;
         mem_wr_data = CLEAR_ROW;
      end else begin
         mem_wr_en   = fire && ctl.wr_en;
         mem_wr_addr = s1_addr;
         mem_wr_data = row_new;
      end
   end

   srrip_row_ram u_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (req_accept),
      .rd_addr (req_addr),
      .rd_data (rd_row)
   );

   srrip_row_update u_update (
      .req     (s1_req_ff),
      .row_cur (row_cur),
      .row_new (row_new),
      .ctl     (ctl)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // no request may be in flight while rows are being cleared
   assert property (@(posedge clock) disable iff (reset)
      clr_ff |-> !s1_valid_ff)
      else $error("request in flight during clearing pass");

   // a request that advances shows up as a response on the next cycle
   assert property (@(posedge clock) disable iff (reset)
      fire |=> rsp_valid_ff)
      else $error("advanced request produced no response");

   // only victim answers carry a nonzero way
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_data_ff.victim_valid) |-> (rsp_data_ff.victim_way == 4'd0))
      else $error("nonzero victim way on a non-query response");

   // forwarding must stay empty until the first write-back after clearing
   assert property (@(posedge clock) disable iff (reset)
      clr_ff |-> !fwd_valid_ff)
      else $error("forwarding row valid during clearing pass");

endmodule

// ===== rtl/srrip_row_ram.sv =====
`timescale 1ns / 1ps

module srrip_row_ram
   import srrip_pkg::*;
(
   input  logic     clock,
   input  logic     wr_en,
   input  addr_type wr_addr,
   input  row_type  wr_data,
   input  logic     rd_en,
   input  addr_type rd_addr,
   output row_type  rd_data
);

   row_type row_mem [SETS];
   row_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         row_mem[wr_addr] <= wr_data;
      end
   end

   // read returns the old row when the same entry is written on this edge
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= row_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/srrip_row_update.sv =====
`timescale 1ns / 1ps

module srrip_row_update
   import srrip_pkg::*;
(
   input  req_type     req,
   input  row_type     row_cur,
   output row_type     row_new,
   output upd_ctl_type ctl
);

   logic       set_ok;
   logic       way_ok;
   logic [1:0] top;
   logic [1:0] lift;
   logic [1:0] val;
   logic       has3;
   logic       has2;
   logic       has1;
   logic [4:0] victim;

   assign set_ok = 32'(req.set_index) < 32'(SETS);
   assign way_ok = 32'(req.way) < 32'(WAYS);

   // largest value in the row and the lift that brings it to the maximum
   always_comb begin
      has3 = 1'b0;
      has2 = 1'b0;
      has1 = 1'b0;
      for (int w = 0; w < WAYS; w++) begin
         val  = row_cur[2*w +: 2];
         has3 = has3 | (val == 2'd3);
         has2 = has2 | (val == 2'd2);
         has1 = has1 | (val == 2'd1);
      end
      if (has3) begin
         top = 2'd3;
      end else if (has2) begin
         top = 2'd2;
      end else if (has1) begin
         top = 2'd1;
      end else begin
         top = 2'd0;
      end
      lift = RRPV_MAX - top;
   end

   // lowest way that holds the largest value becomes the victim
   always_comb begin
      victim = '0;
      for (int w = WAYS - 1; w >= 0; w--) begin
         if (row_cur[2*w +: 2] == top) begin
            victim = 5'(w);
         end
      end
   end

   always_comb begin
      row_new = row_cur;
      ctl     = '0;
      case (req.cmd)
         CMD_HIT: begin
            ctl.wr_en = set_ok && way_ok;
            for (int w = 0; w < WAYS; w++) begin
               if (5'(w) == {1'b0, req.way}) begin
                  row_new[2*w +: 2] = RRPV_HIT;
               end
            end
         end
         CMD_FILL: begin
            ctl.wr_en = set_ok && way_ok;
            for (int w = 0; w < WAYS; w++) begin
               if (5'(w) == {1'b0, req.way}) begin
                  row_new[2*w +: 2] = RRPV_INSERT;
               end
            end
         end
         CMD_QUERY: begin
            ctl.wr_en        = set_ok;
            ctl.victim_valid = 1'b1;
            ctl.victim_way   = set_ok ? victim[3:0] : 4'd0;
            for (int w = 0; w < WAYS; w++) begin
               row_new[2*w +: 2] = row_cur[2*w +: 2] + lift;
            end
         end
         default: begin
            ctl = '0;
         end
      endcase
   end

endmodule

// ===== dv/srrip_victim_checker.sv =====
`timescale 1ns / 1ps

module srrip_victim_checker
   import srrip_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_stall,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_stall,
   input  rsp_type rsp_data,
   output int      fail_count,
   output int      pending_count,
   output int      answer_count,
   output int      victim_count
);

   logic [1:0] rrpv_table [SETS][WAYS];
   rsp_type    victim_queue [$];

   // Apply one request to the shadow RRPV table and return its response.
   function automatic rsp_type apply_request(input req_type r);
      rsp_type    res;
      logic [1:0] peak;
      logic [1:0] lift;
      bit         found;
      int         w;
      res = '0;
      case (r.cmd)
         CMD_HIT: begin
            if (r.set_index < SETS && r.way < WAYS) rrpv_table[r.set_index][r.way] = RRPV_HIT;
         end
         CMD_FILL: begin
            if (r.set_index < SETS && r.way < WAYS)
               rrpv_table[r.set_index][r.way] = RRPV_INSERT;
         end
         CMD_QUERY: begin
            res.victim_valid = 1'b1;
            if (r.set_index < SETS) begin
               peak = RRPV_HIT;
               for (w = 0; w < WAYS; w++) begin
                  if (rrpv_table[r.set_index][w] > peak) peak = rrpv_table[r.set_index][w];
               end
               // age the whole set so at least one way reaches the maximum
               lift = RRPV_MAX - peak;
               for (w = 0; w < WAYS; w++) begin
                  rrpv_table[r.set_index][w] = rrpv_table[r.set_index][w] + lift;
               end
               found = 1'b0;
               for (w = 0; w < WAYS; w++) begin
                  if (!found && rrpv_table[r.set_index][w] == RRPV_MAX) begin
                     res.victim_way = w[3:0];
                     found          = 1'b1;
                  end
               end
            end
         end
         default: ;
      endcase
      return res;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      int      s;
      int      w;
      if (reset) begin
         for (s = 0; s < SETS; s++) begin
            for (w = 0; w < WAYS; w++) rrpv_table[s][w] = RRPV_MAX;
         end
         victim_queue.delete();
         fail_count    = 0;
         answer_count  = 0;
         victim_count  = 0;
         pending_count = 0;
      end else begin
         // retire the response first: it can only belong to an older request
         if (rsp_valid && !rsp_stall) begin
            answer_count++;
            if (victim_queue.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected response, expected none, actual way %0d valid %0b",
                        $time, rsp_data.victim_way, rsp_data.victim_valid);
            end else begin
               want = victim_queue.pop_front();
               if (rsp_data.victim_valid !== want.victim_valid) begin
                  fail_count++;
                  $display("%0t: victim_valid expected %0b actual %0b", $time,
                           want.victim_valid, rsp_data.victim_valid);
               end
               if (rsp_data.victim_way !== want.victim_way) begin
                  fail_count++;
                  $display("%0t: victim_way expected %0d actual %0d", $time,
                           want.victim_way, rsp_data.victim_way);
               end
            end
         end
         if (req_valid && !req_stall) begin
            want = apply_request(req_data);
            if (want.victim_valid) victim_count++;
            victim_queue.push_back(want);
         end
         pending_count = victim_queue.size();
      end
   end

endmodule

// ===== dv/srrip_replacement_policy_core_tb.sv =====
`timescale 1ns / 1ps

module srrip_replacement_policy_core_tb;
   import srrip_pkg::*;

   localparam int ITEM_TARGET = 1700;
   // last stretch of the run goes without any idling
   localparam int QUIET_FROM  = 1500;
   localparam int PAUSE_AT    = 850;

   logic    clock = 1'b0;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   int         fail_count;
   int         pending_count;
   int         answer_count;
   int         victim_count;
   int         sent_count;
   int         idle_odds;
   bit         quiet;
   logic [9:0] hot_sets [6];

   // 12 ns period
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   srrip_replacement_policy_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   srrip_victim_checker checker_inst (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_data      (rsp_data),
      .fail_count    (fail_count),
      .pending_count (pending_count),
      .answer_count  (answer_count),
      .victim_count  (victim_count)
   );

   function automatic req_type make_request(input logic [1:0] cmd, input logic [9:0] set_index,
                                            input logic [3:0] way);
      req_type r;
      r.cmd       = cmd;
      r.set_index = set_index;
      r.way       = way;
      return r;
   endfunction

   // Offer one request from a falling edge and hold it until accepted.
   // An optional idle burst goes in front of it; valid drops only there.
   task automatic send_request(input req_type r);
      if (!quiet && idle_odds != 0 && $urandom_range(0, idle_odds - 1) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (req_stall !== 1'b0);
      sent_count++;
      @(negedge clock);
   endtask

   // Hold the sender off until every outstanding response has come back.
   task automatic drain_responses();
      req_valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
   endtask

   // Touch most ways of one set with hits and fills, then query it a few times.
   // Sweeps that touch every way pull the whole set below the maximum, so the queries age it.
   task automatic sweep_set(input logic [9:0] set_index);
      int hit_bias;
      int w;
      int n;
      hit_bias = $urandom_range(0, 4);
      for (w = 0; w < WAYS; w++) begin
         if ($urandom_range(0, 11) != 0) begin
            send_request(make_request(($urandom_range(0, 3) < hit_bias) ? CMD_HIT : CMD_FILL,
                                      set_index, w[3:0]));
         end
      end
      n = $urandom_range(1, 3);
      repeat (n) send_request(make_request(CMD_QUERY, set_index, 4'($urandom_range(0, 15))));
   endtask

   // Receiver: stall in random bursts, none in the quiet tail.
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (!quiet && idle_odds != 0 && $urandom_range(0, idle_odds - 1) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 18)) @(negedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // Limit: far beyond the slowest correct run, clearing pass included.
   initial begin
      #10_000_000;
      $display("end of test: mismatches");
      $finish;
   end

   initial begin
      int  pick;
      int  w;
      bit  paused;
      reset      = 1'b1;
      req_valid  = 1'b0;
      req_data   = '0;
      quiet      = 1'b0;
      idle_odds  = 6;
      sent_count = 0;
      paused     = 1'b0;
      hot_sets[0] = 10'd0;
      hot_sets[1] = 10'd1023;
      for (w = 2; w < 6; w++) hot_sets[w] = 10'($urandom_range(1, 1022));

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: fresh set answers way 0, a hit moves the victim on,
      // back-to-back requests to one set exercise forwarding.
      send_request(make_request(CMD_QUERY, 10'd0, 4'd15));
      send_request(make_request(CMD_HIT,   10'd0, 4'd0));
      send_request(make_request(CMD_QUERY, 10'd0, 4'd0));
      send_request(make_request(CMD_FILL,  10'd0, 4'd1));
      send_request(make_request(CMD_QUERY, 10'd0, 4'd0));
      // unused command with every field at its top value: no change, empty response
      send_request(make_request(CMD_NOP,   10'd1023, 4'd15));
      // fill even ways, hit odd ways of the top set: no way left at the maximum,
      // so the first query ages the set and the second finds way 0 as is
      for (w = 0; w < WAYS; w++) begin
         send_request(make_request((w % 2 == 0) ? CMD_FILL : CMD_HIT, 10'd1023, w[3:0]));
      end
      send_request(make_request(CMD_QUERY, 10'd1023, 4'd15));
      send_request(make_request(CMD_QUERY, 10'd1023, 4'd0));
      drain_responses();

      // Random: mostly sweeps on a few hot sets, the rest loose traffic.
      while (sent_count < ITEM_TARGET) begin
         quiet = (sent_count >= QUIET_FROM);
         if ($urandom_range(0, 15) == 0) begin
            pick = $urandom_range(0, 2);
            idle_odds = (pick == 0) ? 0 : ((pick == 1) ? 4 : 12);
         end
         if (!paused && sent_count >= PAUSE_AT) begin
            paused = 1'b1;
            drain_responses();
         end
         pick = $urandom_range(0, 99);
         if (pick < 65) begin
            sweep_set(hot_sets[$urandom_range(0, 5)]);
         end else if (pick < 92) begin
            send_request(make_request(2'($urandom_range(0, 3)), hot_sets[$urandom_range(0, 5)],
                                      4'($urandom_range(0, 15))));
         end else begin
            send_request(make_request(2'($urandom_range(0, 3)), 10'($urandom_range(0, 1023)),
                                      4'($urandom_range(0, 15))));
         end
      end

      // Drop valid, wait for the last responses, then a few cycles for strays.
      req_valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (4) @(negedge clock);

      $display("covered %0d requests, %0d victim queries, %0d responses checked", sent_count,
               victim_count, answer_count);
      $display("hits, fills, no-ops, set aging sweeps, same-set back-to-back, two-sided stalls");
      if (fail_count == 0 && pending_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
